>>> hw/rtl/lfpd_pkg.sv
// Shared types, constants and the microcode program of the line follower PID drive.
package lfpd_pkg;

  // Field and state widths
  localparam int SENSOR_W   = 8;   // sensor bits on the input channel
  localparam int WSUM_W     = 7;   // signed sum of sensor positions
  localparam int CNT_W      = 4;   // number of set sensors, 0..8
  localparam int GAIN_W     = 16;
  localparam int TGT_W      = 11;
  localparam int SPD_W      = 7;
  localparam int ERR_W      = 12;
  localparam int DER_W      = ERR_W + 1;
  localparam int SUM_W      = 24;
  localparam int MUL_A_W    = GAIN_W + 1;
  localparam int MUL_B_W    = SUM_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int DUTY_MAX   = 100;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 4;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_TARGET_POS   = 3'd3,
    REG_CRUISE_SPEED = 3'd4,
    REG_SEARCH_SPEED = 3'd5
  } lfpd_reg_e;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_NOP,
    OP_DIV,
    OP_ERR,
    OP_INTEG,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC,
    OP_CORR,
    OP_OUT
  } lfpd_op_e;

  // Jump conditions: jump to the target when the condition holds, else advance
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_SKIP,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } lfpd_cond_e;

  typedef struct packed {
    lfpd_op_e          op;
    lfpd_cond_e        cond;
    logic [STEP_W-1:0] target;
  } lfpd_uword_t;

  typedef struct packed {
    logic no_req;
    logic skip;
    logic div_busy;
    logic out_busy;
  } lfpd_status_t;

  // Program addresses
  localparam logic [STEP_W-1:0] STEP_LOAD  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIV   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ERR   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_INTEG = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_P = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_I = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MUL_D = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ACC   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CORR  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_OUT   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_RET   = 4'd11;

  function automatic lfpd_uword_t lfpd_rom(input logic [STEP_W-1:0] step);
    lfpd_uword_t w;
    case (step)
      STEP_LOAD:  w = '{op: OP_LOAD,  cond: COND_NO_REQ,   target: STEP_LOAD};
      STEP_CHECK: w = '{op: OP_NOP,   cond: COND_SKIP,     target: STEP_OUT};
      STEP_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_BUSY, target: STEP_DIV};
      STEP_ERR:   w = '{op: OP_ERR,   cond: COND_NEXT,     target: STEP_LOAD};
      STEP_INTEG: w = '{op: OP_INTEG, cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_P: w = '{op: OP_MUL_P, cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_I: w = '{op: OP_MUL_I, cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MUL_D: w = '{op: OP_MUL_D, cond: COND_NEXT,     target: STEP_LOAD};
      STEP_ACC:   w = '{op: OP_ACC,   cond: COND_NEXT,     target: STEP_LOAD};
      STEP_CORR:  w = '{op: OP_CORR,  cond: COND_NEXT,     target: STEP_LOAD};
      STEP_OUT:   w = '{op: OP_OUT,   cond: COND_OUT_BUSY, target: STEP_OUT};
      STEP_RET:   w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: STEP_LOAD};
      default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/line_follower_pid_drive.sv
// Top level of the line follower PID drive: datapath, configuration and channels.
//
// Usage: one request on the s_axis channel carries the eight sensor bits of a
// control tick. The block finds the centroid of the set sensors, runs one PID
// step against target_pos and returns one request on m_axis with the left and
// right duty and direction; m_axis_tuser_o flags a lost line (no sensor set),
// in which case the wheels spin in place at search_speed.
// Configuration is a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i),
// written only while the block is idle. The user, not the block, keeps to this.
// Sequence: a tracking tick runs from acceptance through the restoring
// divider, which produces one quotient bit a cycle, the error step, the
// integral and derivative step and one shared 17x24 multiplier used for the
// three PID terms in turn, then the correction and output steps. A lost line
// or a centered line skips the divide and the PID step.
// Reset: gains, target and speeds return to their reset values, the PID
// state clears and no result is pending.
// Stall: a finished result waits in the output register; the sequencer holds
// at its output step while a previous result is still not taken, and new
// sensor requests are accepted once the sequencer returns to its load step.
module line_follower_pid_drive
  import lfpd_pkg::*;
#(
  parameter int SENSOR_COUNT = 8,
  parameter int FRAC_BITS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // sensor requests
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [7:0] sensor_bits
  // drive results
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o,   // [6:0] left_duty, [7] left_reverse,
                                                  // [14:8] right_duty, [15] right_reverse
  output logic                  m_axis_tuser_o    // [0] line_lost
);

  // numerator magnitude: |position sum| shifted up by the fraction bits
  localparam int MAG_W     = WSUM_W - 1 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(MAG_W);
  localparam int CENT_W    = MAG_W + 2;
  localparam int SHIFT     = 8 + FRAC_BITS;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

  function automatic int sensor_pos(input int i);
    int half;
    half = SENSOR_COUNT / 2;
    return (i < half) ? (i - (half - 1)) : (i - half);
  endfunction

  function automatic logic [SPD_W-1:0] clamp_duty(input logic signed [ACC_W:0] v);
    logic [SPD_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > DUTY_MAX) begin
      r = SPD_W'(DUTY_MAX);
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [GAIN_W-1:0]       prop_gain_q, integ_gain_q, deriv_gain_q;
  logic signed [TGT_W-1:0] target_pos_q;
  logic [SPD_W-1:0]        cruise_speed_q, search_speed_q;

  // PID state
  logic signed [ERR_W-1:0] last_error_q;
  logic signed [SUM_W-1:0] error_sum_q, error_sum_d;

  // Working registers
  logic                    neg_q, lost_q, zero_q;
  logic [CNT_W-1:0]        den_q;
  logic [MAG_W-1:0]        div_num_q;
  logic [CNT_W-1:0]        div_rem_q;
  logic [DIV_CNT_W-1:0]    div_cnt_q;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic signed [DER_W-1:0] der_q, der_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q, corr_q, corr_d;

  // Output register
  logic                    out_valid_q;
  logic [SPD_W-1:0]        left_duty_q, right_duty_q;
  logic                    left_rev_q, right_rev_q, lost_out_q;

  lfpd_op_e     op;
  lfpd_status_t status;
  logic         in_accept, out_busy, out_load;

  assign s_axis_tready_o = (op == OP_LOAD);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_busy        = out_valid_q && !m_axis_tready_i;
  assign out_load        = (op == OP_OUT) && !out_busy;

  assign status.no_req   = !s_axis_tvalid_i;
  assign status.skip     = lost_q || zero_q;
  assign status.div_busy = (div_cnt_q != DIV_LAST);
  assign status.out_busy = out_busy;

  lfpd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  // Position sum and count of the set sensors
  logic signed [WSUM_W-1:0] wsum;
  logic [CNT_W-1:0]         cnt;
  logic [WSUM_W-1:0]        wmag;

  always_comb begin
    wsum = '0;
    cnt  = '0;
    for (int i = 0; i < SENSOR_W; i++) begin
      if (i < SENSOR_COUNT && s_axis_tdata_i[i]) begin
        wsum = wsum + WSUM_W'(sensor_pos(i));
        cnt  = cnt + 1'b1;
      end
    end
    wmag = wsum[WSUM_W-1] ? WSUM_W'(-wsum) : WSUM_W'(wsum);
  end

  // Restoring divide step: one quotient bit a cycle
  logic [CNT_W:0] div_shift, div_sub;
  logic           div_ge;

  always_comb begin
    div_shift = {div_rem_q, div_num_q[MAG_W-1]};
    div_ge    = (div_shift >= {1'b0, den_q});
    div_sub   = div_shift - {1'b0, den_q};
  end

  // Error against target, saturated to the error width
  logic signed [CENT_W-1:0] cent, diff;

  always_comb begin
    cent = neg_q ? -$signed({2'b00, div_num_q}) : $signed({2'b00, div_num_q});
    diff = cent - CENT_W'(target_pos_q);
    if (diff > (2 ** (ERR_W - 1)) - 1) begin
      err_d = ERR_W'((2 ** (ERR_W - 1)) - 1);
    end else if (diff < -(2 ** (ERR_W - 1))) begin
      err_d = ERR_W'(-(2 ** (ERR_W - 1)));
    end else begin
      err_d = diff[ERR_W-1:0];
    end
  end

  // Integral with saturation, derivative
  logic signed [SUM_W:0] sum_full;

  always_comb begin
    sum_full = (SUM_W+1)'(error_sum_q) + (SUM_W+1)'(err_q);
    if (sum_full > (2 ** (SUM_W - 1)) - 1) begin
      error_sum_d = SUM_W'((2 ** (SUM_W - 1)) - 1);
    end else if (sum_full < -(2 ** (SUM_W - 1))) begin
      error_sum_d = SUM_W'(-(2 ** (SUM_W - 1)));
    end else begin
      error_sum_d = sum_full[SUM_W-1:0];
    end
    der_d = DER_W'(err_q) - DER_W'(last_error_q);
  end

  // Shared multiplier: gain times error, integral or derivative
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    case (op)
      OP_MUL_P: begin
        mul_a = $signed({1'b0, prop_gain_q});
        mul_b = MUL_B_W'(err_q);
      end
      OP_MUL_I: begin
        mul_a = $signed({1'b0, integ_gain_q});
        mul_b = error_sum_q;
      end
      OP_MUL_D: begin
        mul_a = $signed({1'b0, deriv_gain_q});
        mul_b = MUL_B_W'(der_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Shift down toward zero: bias negative sums before the arithmetic shift
  logic signed [ACC_W-1:0] corr_bias;

  always_comb begin
    corr_bias = acc_q[ACC_W-1] ? ACC_W'((2 ** SHIFT) - 1) : '0;
    corr_d    = (acc_q + corr_bias) >>> SHIFT;
  end

  // Duties
  logic signed [ACC_W:0] left_sum, right_sum;
  logic [SPD_W-1:0]      search_duty;

  always_comb begin
    left_sum    = (ACC_W+1)'(corr_q) + $signed({{(ACC_W+1-SPD_W){1'b0}}, cruise_speed_q});
    right_sum   = $signed({{(ACC_W+1-SPD_W){1'b0}}, cruise_speed_q}) - (ACC_W+1)'(corr_q);
    search_duty = (search_speed_q > SPD_W'(DUTY_MAX)) ? SPD_W'(DUTY_MAX) : search_speed_q;
  end

  // Configuration and PID state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= GAIN_W'(6400);
      integ_gain_q   <= '0;
      deriv_gain_q   <= GAIN_W'(3840);
      target_pos_q   <= '0;
      cruise_speed_q <= SPD_W'(70);
      search_speed_q <= SPD_W'(30);
      last_error_q   <= '0;
      error_sum_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (lfpd_reg_e'(cfg_addr_i))
          REG_PROP_GAIN:    prop_gain_q    <= cfg_wdata_i[GAIN_W-1:0];
          REG_INTEG_GAIN:   integ_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
          REG_DERIV_GAIN:   deriv_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
          REG_TARGET_POS:   target_pos_q   <= $signed(cfg_wdata_i[TGT_W-1:0]);
          REG_CRUISE_SPEED: cruise_speed_q <= cfg_wdata_i[SPD_W-1:0];
          REG_SEARCH_SPEED: search_speed_q <= cfg_wdata_i[SPD_W-1:0];
          default: ;
        endcase
      end
      // commit the PID state once per tracked tick
      if (op == OP_INTEG) begin
        error_sum_q  <= error_sum_d;
        last_error_q <= err_q;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        if (in_accept) begin
          neg_q     <= wsum[WSUM_W-1];
          lost_q    <= (cnt == '0);
          zero_q    <= (wsum == '0);
          den_q     <= cnt;
          div_num_q <= {wmag[WSUM_W-2:0], {FRAC_BITS{1'b0}}};
          div_rem_q <= '0;
          div_cnt_q <= '0;
          corr_q    <= '0;
        end
      end
      OP_DIV: begin
        div_rem_q <= div_ge ? div_sub[CNT_W-1:0] : div_shift[CNT_W-1:0];
        div_num_q <= {div_num_q[MAG_W-2:0], div_ge};
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      OP_ERR:   err_q <= err_d;
      OP_INTEG: der_q <= der_d;
      OP_MUL_P: prod_q <= prod_d;
      OP_MUL_I: begin
        acc_q  <= ACC_W'(prod_q);
        prod_q <= prod_d;
      end
      OP_MUL_D: begin
        acc_q  <= acc_q + ACC_W'(prod_q);
        prod_q <= prod_d;
      end
      OP_ACC:  acc_q  <= acc_q + ACC_W'(prod_q);
      OP_CORR: corr_q <= corr_d;
      default: ;
    endcase
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (lost_q) begin
        left_duty_q  <= search_duty;
        right_duty_q <= search_duty;
        left_rev_q   <= 1'b0;
        right_rev_q  <= 1'b1;
        lost_out_q   <= 1'b1;
      end else begin
        left_duty_q  <= clamp_duty(left_sum);
        right_duty_q <= clamp_duty(right_sum);
        left_rev_q   <= 1'b0;
        right_rev_q  <= 1'b0;
        lost_out_q   <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {right_rev_q, right_duty_q, left_rev_q, left_duty_q};
  assign m_axis_tuser_o  = lost_out_q;

`ifndef SYNTHESIS
  a_lost_spin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      !m_axis_tdata_o[7] && m_axis_tdata_o[15] &&
      (m_axis_tdata_o[6:0] == m_axis_tdata_o[14:8]))
    else $error("lost line result is not a spin in place");

  a_track_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> !m_axis_tdata_o[7] && !m_axis_tdata_o[15])
    else $error("tracking result drives a wheel backward");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[6:0] <= 7'd100) && (m_axis_tdata_o[14:8] <= 7'd100))
    else $error("duty above full scale");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("sequencer did not leave the load step after a request");
`endif

endmodule

>>> hw/rtl/lfpd_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module lfpd_seq
  import lfpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lfpd_status_t status_i,
  output lfpd_op_e     op_o
);

  logic [STEP_W-1:0] step_q, step_d;
  lfpd_uword_t       uword;
  logic              take;

  assign uword = lfpd_rom(step_q);
  assign op_o  = uword.op;

  always_comb begin
    case (uword.cond)
      COND_NEXT:     take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_REQ:   take = status_i.no_req;
      COND_SKIP:     take = status_i.skip;
      COND_DIV_BUSY: take = status_i.div_busy;
      COND_OUT_BUSY: take = status_i.out_busy;
      default:       take = 1'b0;
    endcase
    step_d = take ? uword.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
